// File: hdl/adb_pkg.sv
// Package for the anti-aliased disc blend block.
// Holds the pixel transfer types, register codes and shared constants.
// No dependencies.
package adb_pkg;

    // Default disc radius in pixels.
    localparam int unsigned RADIUS_DEF = 8;

    // Disc colour components after reset (0.3 of full scale).
    localparam logic [7:0] DISC_RESET = 8'd77;

    // Configuration port geometry.
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;

    // Register index taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_DISC_RED   = 2'd0,
        REG_DISC_GREEN = 2'd1,
        REG_DISC_BLUE  = 2'd2
    } t_reg_idx;

    // Where a pixel lies relative to the disc.
    typedef enum logic [1:0] {
        ZONE_CORE,
        ZONE_EDGE,
        ZONE_OUT
    } t_zone;

    // One colour triple.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // Input pixel transfer.
    typedef struct packed {
        logic [9:0] pixel_x;
        logic [9:0] pixel_y;
        logic [9:0] center_x;
        logic [9:0] center_y;
        logic [7:0] dest_red;
        logic [7:0] dest_green;
        logic [7:0] dest_blue;
    } t_pix_in;

    // Output pixel transfer.
    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       covered;
    } t_pix_out;

endpackage

// File: hdl/antialiased_disc_blend_top.sv
// Top level of the anti-aliased disc blend shader.
// Depends on adb_pkg for transfer types, register codes and constants.
//
// The block shades one pixel per clock while the pipeline is not stalled: a new
// input transfer can be taken in any cycle in which the first stage can move.
// Each pixel passes through a six-stage pipeline: absolute differences, the
// two coordinate squarers, the distance sum and zone compare, the smoothstep
// weight table, the blend multipliers, and the rounding and output register.
// A stalled output only holds the stages that are occupied; empty stages keep
// filling. The smoothstep weight is a constant table of 2**$clog2(2*RADIUS+1)
// entries built at elaboration, of which the first 2*RADIUS+1 are used. The
// disc colour registers sit at byte addresses 0, 4 and 8 and reset to 77.
module antialiased_disc_blend_top #(
    parameter int unsigned RADIUS = adb_pkg::RADIUS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Pixel input channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  adb_pkg::t_pix_in                i_in_data,
    // Pixel output channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output adb_pkg::t_pix_out               o_out_data,
    // Configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [adb_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [adb_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [adb_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import adb_pkg::*;

    localparam int unsigned D_W   = 21;
    localparam int unsigned R2    = RADIUS * RADIUS;
    localparam int unsigned E2    = (RADIUS + 1) * (RADIUS + 1);
    localparam int unsigned SPAN  = 2 * RADIUS + 1;
    localparam int unsigned OFS_W = $clog2(SPAN);
    localparam int unsigned LUT_N = 2 ** OFS_W;

    // Smoothstep weight table in Q0.16, indexed by d - R^2.
    logic [15:0] t_lut [LUT_N];

    for (genvar g = 0; g < LUT_N; g++) begin : g_lut
        localparam longint unsigned LU  = (longint'(g) << 16) / SPAN;
        localparam longint unsigned LU2 = (LU * LU) >> 16;
        localparam longint unsigned LT0 = (LU2 * (3 * 65536 - 2 * LU)) >> 16;
        localparam longint unsigned LT  = (LT0 > 65535) ? 65535 : LT0;
        assign t_lut[g] = (g < SPAN) ? 16'(LT) : 16'd0;
    end

    // Disc colour registers
    t_rgb     r_disc;
    t_reg_idx w_idx;
    logic     w_cfg_wr;

    assign pready   = 1'b1;
    assign w_idx    = t_reg_idx'(paddr[3:2]);
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disc <= '{DISC_RESET, DISC_RESET, DISC_RESET};
        end else if (w_cfg_wr) begin
            unique case (w_idx)
                REG_DISC_RED:   r_disc.red   <= pwdata[7:0];
                REG_DISC_GREEN: r_disc.green <= pwdata[7:0];
                REG_DISC_BLUE:  r_disc.blue  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (w_idx)
            REG_DISC_RED:   prdata = {24'd0, r_disc.red};
            REG_DISC_GREEN: prdata = {24'd0, r_disc.green};
            REG_DISC_BLUE:  prdata = {24'd0, r_disc.blue};
            default:        prdata = '0;
        endcase
    end

    // Pipeline registers
    logic              r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld, r_s5_vld, r_s6_vld;
    logic              en1, en2, en3, en4, en5, en6;
    logic [9:0]        r_s1_dx, r_s1_dy;
    t_rgb              r_s1_dest, r_s2_dest, r_s3_dest, r_s4_dest;
    logic [19:0]       r_s2_sqx, r_s2_sqy;
    t_zone             r_s3_zone, r_s4_zone, r_s5_zone;
    logic [OFS_W-1:0]  r_s3_ofs;
    logic [15:0]       r_s4_t;
    logic [23:0]       r_s5_pd_r, r_s5_pd_g, r_s5_pd_b;
    logic [24:0]       r_s5_pc_r, r_s5_pc_g, r_s5_pc_b;
    t_rgb              r_s5_dest;
    t_pix_out          r_s6_out;

    logic [D_W-1:0]    n_d;
    logic [D_W-1:0]    n_ofs_full;
    logic [16:0]       n_inv_t;

    // A stage moves when it is empty or the stage after it moves.
    always_comb begin
        en6 = !r_s6_vld || i_out_ready;
        en5 = !r_s5_vld || en6;
        en4 = !r_s4_vld || en5;
        en3 = !r_s3_vld || en4;
        en2 = !r_s2_vld || en3;
        en1 = !r_s1_vld || en2;
    end

    assign o_in_ready  = en1;
    assign o_out_valid = r_s6_vld;
    assign o_out_data  = r_s6_out;

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
            r_s6_vld <= 1'b0;
        end else begin
            if (en1) r_s1_vld <= i_in_valid;
            if (en2) r_s2_vld <= r_s1_vld;
            if (en3) r_s3_vld <= r_s2_vld;
            if (en4) r_s4_vld <= r_s3_vld;
            if (en5) r_s5_vld <= r_s4_vld;
            if (en6) r_s6_vld <= r_s5_vld;
        end
    end

    // Stage 1: absolute coordinate differences.
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_dx <= (i_in_data.pixel_x >= i_in_data.center_x)
                     ? i_in_data.pixel_x - i_in_data.center_x
                     : i_in_data.center_x - i_in_data.pixel_x;
            r_s1_dy <= (i_in_data.pixel_y >= i_in_data.center_y)
                     ? i_in_data.pixel_y - i_in_data.center_y
                     : i_in_data.center_y - i_in_data.pixel_y;
            r_s1_dest <= '{i_in_data.dest_red, i_in_data.dest_green, i_in_data.dest_blue};
        end
    end

    // Stage 2: squares of the differences.
    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_sqx  <= 20'(r_s1_dx) * 20'(r_s1_dx);
            r_s2_sqy  <= 20'(r_s1_dy) * 20'(r_s1_dy);
            r_s2_dest <= r_s1_dest;
        end
    end

    // Stage 3: squared distance, zone and offset into the edge band.
    always_comb begin
        n_d        = D_W'(r_s2_sqx) + D_W'(r_s2_sqy);
        n_ofs_full = n_d - D_W'(R2);
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            if (n_d < D_W'(R2)) begin
                r_s3_zone <= ZONE_CORE;
            end else if (n_d < D_W'(E2)) begin
                r_s3_zone <= ZONE_EDGE;
            end else begin
                r_s3_zone <= ZONE_OUT;
            end
            r_s3_ofs  <= n_ofs_full[OFS_W-1:0];
            r_s3_dest <= r_s2_dest;
        end
    end

    // Stage 4: smoothstep weight; a core pixel takes weight zero, the full disc.
    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_s4_t    <= (r_s3_zone == ZONE_EDGE) ? t_lut[r_s3_ofs] : 16'd0;
            r_s4_zone <= r_s3_zone;
            r_s4_dest <= r_s3_dest;
        end
    end

    // Stage 5: blend products per channel.
    assign n_inv_t = 17'h10000 - 17'(r_s4_t);

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r_s5_pd_r <= 24'(r_s4_dest.red)   * 24'(r_s4_t);
            r_s5_pd_g <= 24'(r_s4_dest.green) * 24'(r_s4_t);
            r_s5_pd_b <= 24'(r_s4_dest.blue)  * 24'(r_s4_t);
            r_s5_pc_r <= 25'(r_disc.red)   * 25'(n_inv_t);
            r_s5_pc_g <= 25'(r_disc.green) * 25'(n_inv_t);
            r_s5_pc_b <= 25'(r_disc.blue)  * 25'(n_inv_t);
            r_s5_zone <= r_s4_zone;
            r_s5_dest <= r_s4_dest;
        end
    end

    // Round half up to 8 bits and saturate.
    function automatic logic [7:0] round_sat(input logic [23:0] pd, input logic [24:0] pc);
        logic [25:0] sum;
        sum = 26'(pd) + 26'(pc) + 26'h8000;
        return (sum[25:24] != 2'd0) ? 8'hFF : sum[23:16];
    endfunction

    // Stage 6: output register; outside pixels pass through uncovered.
    always_ff @(posedge i_clk) begin
        if (en6) begin
            if (r_s5_zone == ZONE_OUT) begin
                r_s6_out <= '{r_s5_dest.red, r_s5_dest.green, r_s5_dest.blue, 1'b0};
            end else begin
                r_s6_out <= '{round_sat(r_s5_pd_r, r_s5_pc_r),
                              round_sat(r_s5_pd_g, r_s5_pc_g),
                              round_sat(r_s5_pd_b, r_s5_pc_b),
                              1'b1};
            end
        end
    end

endmodule

// File: tb/sv/antialiased_disc_blend_top_tb.sv
// Self-checking testbench for the anti-aliased disc blend shader.
// Depends on adb_pkg and antialiased_disc_blend_top; runs directed rows, then random pixels.
// Every output is checked against its typed result or a built-in smoothstep predictor.
module antialiased_disc_blend_top_tb;
    import adb_pkg::*;

    localparam int unsigned RAD         = RADIUS_DEF;
    localparam int          N_ROWS      = 24;
    localparam int          N_PHASES    = 6;
    localparam int          PHASE_ITEMS = 275;
    localparam int          DRAIN       = 16;
    localparam int          CYCLE_LIMIT = 500000;

    // One directed row: the pixel, and its result where it is obvious.
    typedef struct {
        t_pix_in  pix;
        bit       typed;
        t_pix_out result;
    } t_shade_row;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    t_pix_in               in_data;
    logic                  out_valid;
    logic                  out_ready;
    t_pix_out              out_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    t_pix_out expected_pixels [$];
    t_rgb     disc_colour;
    int       send_idle_pct;
    int       recv_idle_pct;
    int       n_fail = 0;
    int       cycle_count = 0;

    // Rows around the centre, both rim radii and the frame border, at reset colour.
    t_shade_row shade_rows [N_ROWS] = '{
        '{'{10'd0, 10'd0, 10'd0, 10'd0, 8'd0, 8'd0, 8'd0}, 1'b1,
          '{8'd77, 8'd77, 8'd77, 1'b1}},
        '{'{10'd1023, 10'd1023, 10'd1023, 10'd1023, 8'd255, 8'd255, 8'd255}, 1'b1,
          '{8'd77, 8'd77, 8'd77, 1'b1}},
        '{'{10'd0, 10'd0, 10'd1023, 10'd1023, 8'd12, 8'd34, 8'd56}, 1'b1,
          '{8'd12, 8'd34, 8'd56, 1'b0}},
        '{'{10'd1023, 10'd1023, 10'd0, 10'd0, 8'd255, 8'd255, 8'd255}, 1'b1,
          '{8'd255, 8'd255, 8'd255, 1'b0}},
        '{'{10'd0, 10'd1023, 10'd1023, 10'd0, 8'd0, 8'd0, 8'd0}, 1'b1,
          '{8'd0, 8'd0, 8'd0, 1'b0}},
        '{'{10'd507, 10'd500, 10'd500, 10'd503, 8'd200, 8'd10, 8'd99}, 1'b1,
          '{8'd77, 8'd77, 8'd77, 1'b1}},
        '{'{10'd508, 10'd500, 10'd500, 10'd500, 8'd255, 8'd0, 8'd128}, 1'b1,
          '{8'd77, 8'd77, 8'd77, 1'b1}},
        '{'{10'd500, 10'd492, 10'd500, 10'd500, 8'd0, 8'd255, 8'd3}, 1'b1,
          '{8'd77, 8'd77, 8'd77, 1'b1}},
        '{'{10'd509, 10'd500, 10'd500, 10'd500, 8'd1, 8'd2, 8'd3}, 1'b1,
          '{8'd1, 8'd2, 8'd3, 1'b0}},
        '{'{10'd500, 10'd491, 10'd500, 10'd500, 8'd254, 8'd253, 8'd252}, 1'b1,
          '{8'd254, 8'd253, 8'd252, 1'b0}},
        '{'{10'd508, 10'd504, 10'd500, 10'd500, 8'd255, 8'd255, 8'd255}, 1'b0, '0},
        '{'{10'd496, 10'd492, 10'd500, 10'd500, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
        '{'{10'd508, 10'd501, 10'd500, 10'd500, 8'd200, 8'd100, 8'd50}, 1'b0, '0},
        '{'{10'd492, 10'd502, 10'd500, 10'd500, 8'd0, 8'd128, 8'd255}, 1'b0, '0},
        '{'{10'd506, 10'd506, 10'd500, 10'd500, 8'd255, 8'd0, 8'd0}, 1'b0, '0},
        '{'{10'd495, 10'd507, 10'd500, 10'd500, 8'd10, 8'd20, 8'd30}, 1'b0, '0},
        '{'{10'd0, 10'd0, 10'd3, 10'd4, 8'd9, 8'd9, 8'd9}, 1'b1,
          '{8'd77, 8'd77, 8'd77, 1'b1}},
        '{'{10'd1023, 10'd0, 10'd1016, 10'd4, 8'd100, 8'd100, 8'd100}, 1'b0, '0},
        '{'{10'd0, 10'd1023, 10'd1, 10'd1015, 8'd250, 8'd5, 8'd125}, 1'b0, '0},
        '{'{10'd2, 10'd2, 10'd1021, 10'd1021, 8'd64, 8'd32, 8'd16}, 1'b1,
          '{8'd64, 8'd32, 8'd16, 1'b0}},
        '{'{10'd512, 10'd512, 10'd511, 10'd511, 8'd255, 8'd255, 8'd255}, 1'b1,
          '{8'd77, 8'd77, 8'd77, 1'b1}},
        '{'{10'd0, 10'd0, 10'd8, 10'd8, 8'd7, 8'd8, 8'd9}, 1'b1,
          '{8'd7, 8'd8, 8'd9, 1'b0}},
        '{'{10'd1023, 10'd1023, 10'd1015, 10'd1023, 8'd0, 8'd0, 8'd0}, 1'b1,
          '{8'd77, 8'd77, 8'd77, 1'b1}},
        '{'{10'd683, 10'd341, 10'd341, 10'd682, 8'hAA, 8'h55, 8'hAA}, 1'b1,
          '{8'hAA, 8'h55, 8'hAA, 1'b0}}
    };

    antialiased_disc_blend_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Clock generation.
    initial begin
        clk = 1'b0;
        forever begin
            #10 clk = ~clk;
        end
    end

    // Mixes one destination channel with the disc channel by weight w (Q0.16).
    function automatic logic [7:0] blend_channel(input logic [7:0] dest,
                                                 input logic [7:0] disc,
                                                 input longint unsigned w);
        longint unsigned mix;
        mix = (dest * w + disc * (65536 - w) + 32768) >> 16;
        if (mix > 255) begin
            mix = 255;
        end
        return mix[7:0];
    endfunction

    // Predicts the shaded pixel from the inputs and the disc colour.
    function automatic t_pix_out shade_pixel(input t_pix_in p, input t_rgb disc);
        int unsigned     dx;
        int unsigned     dy;
        int unsigned     sq_dist;
        int unsigned     inner_sq;
        int unsigned     outer_sq;
        longint unsigned ramp;
        longint unsigned ramp_sq;
        longint unsigned weight;
        t_pix_out        shaded;
        inner_sq = RAD * RAD;
        outer_sq = (RAD + 1) * (RAD + 1);
        dx = (p.pixel_x >= p.center_x) ? int'(p.pixel_x) - int'(p.center_x)
                                       : int'(p.center_x) - int'(p.pixel_x);
        dy = (p.pixel_y >= p.center_y) ? int'(p.pixel_y) - int'(p.center_y)
                                       : int'(p.center_y) - int'(p.pixel_y);
        sq_dist = dx * dx + dy * dy;
        if (sq_dist < inner_sq) begin
            shaded = '{disc.red, disc.green, disc.blue, 1'b1};
        end else if (sq_dist < outer_sq) begin
            // Smoothstep weight across the one-pixel rim.
            ramp = (longint'(sq_dist - inner_sq) << 16) / (outer_sq - inner_sq);
            if (ramp > 65535) begin
                ramp = 65535;
            end
            ramp_sq = (ramp * ramp) >> 16;
            weight = (ramp_sq * (3 * 65536 - 2 * ramp)) >> 16;
            if (weight > 65535) begin
                weight = 65535;
            end
            shaded.out_red   = blend_channel(p.dest_red, disc.red, weight);
            shaded.out_green = blend_channel(p.dest_green, disc.green, weight);
            shaded.out_blue  = blend_channel(p.dest_blue, disc.blue, weight);
            shaded.covered   = 1'b1;
        end else begin
            shaded = '{p.dest_red, p.dest_green, p.dest_blue, 1'b0};
        end
        return shaded;
    endfunction

    // Sends one pixel; entered and left at a falling edge. The expected
    // result is queued when the transfer is accepted.
    task automatic send_pixel(input t_pix_in pix, input t_pix_out want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= pix;
        do @(posedge clk); while (!in_ready);
        expected_pixels.push_back(want);
        @(negedge clk);
    endtask

    // Writes one disc colour register, with junk in the unused upper bits.
    task automatic write_disc_reg(input t_reg_idx idx, input logic [7:0] level);
        logic [31:0] junk;
        junk = $urandom();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= {junk[31:8], level};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_DISC_RED: begin
                disc_colour.red = level;
            end
            REG_DISC_GREEN: begin
                disc_colour.green = level;
            end
            default: begin
                disc_colour.blue = level;
            end
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // Output side: random stalls, changed at the falling edge.
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Compare each output transfer with the oldest expected pixel.
    always @(posedge clk) begin : check_out
        t_pix_out want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_pixels.size() == 0) begin
                $error("unexpected output transfer: %p", out_data);
                n_fail++;
            end else begin
                want = expected_pixels.pop_front();
                if (out_data.out_red !== want.out_red) begin
                    $error("out_red mismatch: expected %0d, got %0d",
                           want.out_red, out_data.out_red);
                    n_fail++;
                end
                if (out_data.out_green !== want.out_green) begin
                    $error("out_green mismatch: expected %0d, got %0d",
                           want.out_green, out_data.out_green);
                    n_fail++;
                end
                if (out_data.out_blue !== want.out_blue) begin
                    $error("out_blue mismatch: expected %0d, got %0d",
                           want.out_blue, out_data.out_blue);
                    n_fail++;
                end
                if (out_data.covered !== want.covered) begin
                    $error("covered mismatch: expected %0d, got %0d",
                           want.covered, out_data.covered);
                    n_fail++;
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Stimulus: reset, directed rows, then random phases at several disc colours.
    initial begin
        t_pix_in pix;
        t_rgb    phase_colour [N_PHASES];
        int      kind;
        int      dx;
        int      dy;
        int      tmp;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        send_idle_pct = 26;
        recv_idle_pct = 83;
        disc_colour   = '{DISC_RESET, DISC_RESET, DISC_RESET};

        phase_colour[0] = '{8'd0, 8'd0, 8'd0};
        phase_colour[1] = '{8'd255, 8'd255, 8'd255};
        phase_colour[2] = '{8'd255, 8'd0, 8'd128};
        phase_colour[3] = t_rgb'(24'($urandom()));
        phase_colour[4] = '{8'd1, 8'd254, 8'd77};
        phase_colour[5] = t_rgb'(24'($urandom()));

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed rows at the reset colour.
        for (int r = 0; r < N_ROWS; r++) begin
            send_pixel(shade_rows[r].pix,
                       shade_rows[r].typed ? shade_rows[r].result
                                           : shade_pixel(shade_rows[r].pix, disc_colour));
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            // Let the pipeline empty before touching the colour registers.
            in_valid <= 1'b0;
            while (expected_pixels.size() != 0) @(posedge clk);
            repeat (DRAIN) @(negedge clk);
            write_disc_reg(REG_DISC_RED, phase_colour[ph].red);
            write_disc_reg(REG_DISC_GREEN, phase_colour[ph].green);
            write_disc_reg(REG_DISC_BLUE, phase_colour[ph].blue);

            case (ph / 2)
                0: begin
                    send_idle_pct = 26;
                    recv_idle_pct = 83;
                end
                1: begin
                    send_idle_pct = 83;
                    recv_idle_pct = 26;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                kind = $urandom_range(0, 99);
                pix.pixel_x    = 10'($urandom());
                pix.pixel_y    = 10'($urandom());
                pix.center_x   = 10'($urandom());
                pix.center_y   = 10'($urandom());
                pix.dest_red   = 8'($urandom());
                pix.dest_green = 8'($urandom());
                pix.dest_blue  = 8'($urandom());
                if (kind < 70) begin
                    if (kind < 50) begin
                        // Hug the rim: smallest dy that reaches the inner radius.
                        dx = $urandom_range(0, RAD);
                        dy = 0;
                        while (dx * dx + dy * dy < RAD * RAD) begin
                            dy++;
                        end
                        dy += $urandom_range(0, 1);
                        if ($urandom_range(0, 1)) begin
                            tmp = dx;
                            dx  = dy;
                            dy  = tmp;
                        end
                    end else begin
                        dx = $urandom_range(0, RAD + 2);
                        dy = $urandom_range(0, RAD + 2);
                    end
                    // Coordinates wrap at the frame width.
                    pix.pixel_x = $urandom_range(0, 1) ? 10'(int'(pix.center_x) + dx)
                                                       : 10'(int'(pix.center_x) - dx);
                    pix.pixel_y = $urandom_range(0, 1) ? 10'(int'(pix.center_y) + dy)
                                                       : 10'(int'(pix.center_y) - dy);
                end
                send_pixel(pix, shade_pixel(pix, disc_colour));
            end
        end
        in_valid <= 1'b0;

        // Drain and report.
        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (n_fail == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
